// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/isws_pkg.sv =====
package isws_pkg;

    localparam int ISWS_STACK_DEPTH = 256;
    localparam int ISWS_DATA_WIDTH  = 32;

    localparam int VAL_W = 32;
    localparam int CNT_W = 9;
    localparam int SUM_W = 64;

    typedef enum logic [2:0] {
        FUNC_PUSH       = 3'd0,
        FUNC_PUSH_PAIR  = 3'd1,
        FUNC_POP        = 3'd2,
        FUNC_POP_PAIR   = 3'd3,
        FUNC_POP_COUNT  = 3'd4,
        FUNC_READ_TOP   = 3'd5,
        FUNC_STATS      = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_UNDER = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH2,
        ST_SCAN,
        ST_SDRAIN,
        ST_DSTART,
        ST_DIV,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]              func;
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
        logic [CNT_W-1:0]        pop_amount;
    } in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] top_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_empty;
        logic                    is_full;
        logic signed [VAL_W-1:0] mean_value;
        logic signed [VAL_W-1:0] min_value;
        logic signed [VAL_W-1:0] max_value;
        logic [CNT_W-1:0]        even_count;
        logic [CNT_W-1:0]        odd_count;
    } out_t;

endpackage

// ===== src/isws_mem.sv =====
module isws_mem
    import isws_pkg::*;
#(
    parameter int DEPTH = ISWS_STACK_DEPTH,
    parameter int WIDTH = ISWS_DATA_WIDTH
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/isws_stats.sv =====
module isws_stats
    import isws_pkg::*;
#(
    parameter int DATA_WIDTH = ISWS_DATA_WIDTH,
    parameter int CNT_WIDTH  = CNT_W
)(
    input  logic                         clk,
    input  logic                         clear,
    input  logic                         sample_vld,
    input  logic [DATA_WIDTH-1:0]        sample,
    output logic signed [SUM_W-1:0]      sum,
    output logic signed [DATA_WIDTH-1:0] min_val,
    output logic signed [DATA_WIDTH-1:0] max_val,
    output logic [CNT_WIDTH-1:0]         even_cnt
);

    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [DATA_WIDTH-1:0] min_reg, min_next;
    logic signed [DATA_WIDTH-1:0] max_reg, max_next;
    logic [CNT_WIDTH-1:0]         even_reg, even_next;
    logic signed [DATA_WIDTH-1:0] smp;

    assign smp = $signed(sample);

    always_comb
    begin
        sum_next  = sum_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        even_next = even_reg;
        if (clear)
        begin
            sum_next  = '0;
            min_next  = $signed({1'b0, {(DATA_WIDTH-1){1'b1}}});
            max_next  = $signed({1'b1, {(DATA_WIDTH-1){1'b0}}});
            even_next = '0;
        end
        else if (sample_vld)
        begin
            // sum wraps modulo 2^64
            sum_next = sum_reg + SUM_W'(smp);
            if (smp < min_reg)
            begin
                min_next = smp;
            end
            if (smp > max_reg)
            begin
                max_next = smp;
            end
            if (!sample[0])
            begin
                even_next = even_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
        even_reg <= even_next;
    end

    assign sum      = sum_reg;
    assign min_val  = min_reg;
    assign max_val  = max_reg;
    assign even_cnt = even_reg;

endmodule

// ===== src/isws_div.sv =====
module isws_div
    import isws_pkg::*;
#(
    parameter int DIVISOR_W = CNT_W
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SUM_W-1:0]     num_reg, num_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W:0]   trial, diff;
    logic                 fits;

    // restoring division on the magnitude, one quotient bit per cycle
    assign trial = {rem_reg, num_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            neg_next  = dividend[SUM_W-1];
            num_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
        end
        else if (run_reg)
        begin
            num_next  = {num_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        step_reg <= step_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(~num_reg + 1'b1) : $signed(num_reg);

endmodule

// ===== src/integer_stack_with_statistics.sv =====
// Push, pop, pop pair, pop count, read top: accept in IDLE, then READ, then the result
// strobe in OUT (push pair passes PUSH2 first); the next command is taken back in IDLE.
// READ holds the memory read of the new top. Statistics: one memory read per stored entry
// in SCAN and the serial divider for the mean. One command at a time; busy high meanwhile.
// Reset clears the entry count and control state; stored entries are not cleared.
// Results are shown for one cycle with done; the receiver cannot stall.
`include "assert_macros.svh"

module integer_stack_with_statistics
    import isws_pkg::*;
#(
    parameter int STACK_DEPTH = ISWS_STACK_DEPTH,
    parameter int DATA_WIDTH  = ISWS_DATA_WIDTH
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  in_t  cmd,
    output logic busy,
    output logic done,
    output out_t result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int XW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    status_t                 status_reg, status_next;
    logic                    stats_req_reg, stats_req_next;
    logic                    scan_vld_reg, scan_vld_next;
    logic [DATA_WIDTH-1:0]   vb_reg, vb_next;
    logic [CW-1:0]           idx_reg, idx_next;

    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0]   mem_wdata, mem_rdata;

    logic                    st_clear;
    logic signed [SUM_W-1:0] st_sum;
    logic signed [DATA_WIDTH-1:0] st_min, st_max;
    logic [CW-1:0]           st_even;

    logic                    div_start, div_done;
    logic signed [SUM_W-1:0] div_quot;

    logic [XW-1:0]           count_x, amount_x, even_x, odd_x;
    logic [CW-1:0]           cnt_m1, odd_cnt;
    logic [CW:0]             cnt_p2;
    logic                    cnt_zero, cnt_full, room2, pop_ok, scan_last;
    logic signed [SUM_W-1:0] va_ext, vb_ext, top_ext, min_ext, max_ext;

    assign count_x   = XW'(count_reg);
    assign amount_x  = XW'(cmd.pop_amount);
    assign cnt_zero  = (count_reg == '0);
    assign cnt_full  = (count_reg == DEPTH_C);
    assign cnt_p2    = {1'b0, count_reg} + (CW + 1)'(2);
    assign room2     = (cnt_p2 <= {1'b0, DEPTH_C});
    assign pop_ok    = !cnt_zero && (amount_x <= count_x);
    assign cnt_m1    = count_reg - 1'b1;
    assign scan_last = (idx_reg == cnt_m1);
    assign va_ext    = SUM_W'($signed(cmd.value_a));
    assign vb_ext    = SUM_W'($signed(cmd.value_b));

    isws_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    isws_stats #(
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_WIDTH  (CW)
    ) u_stats (
        .clk        (clk),
        .clear      (st_clear),
        .sample_vld (scan_vld_reg),
        .sample     (mem_rdata),
        .sum        (st_sum),
        .min_val    (st_min),
        .max_val    (st_max),
        .even_cnt   (st_even)
    );

    isws_div #(
        .DIVISOR_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (st_sum),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.func == FUNC_PUSH_PAIR && room2)
                    begin
                        state_next = ST_PUSH2;
                    end
                    else if (cmd.func == FUNC_STATS && !cnt_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_PUSH2:  state_next = ST_READ;
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_SDRAIN;
                end
            end
            ST_SDRAIN: state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        stats_req_next = stats_req_reg;
        vb_next        = vb_reg;
        idx_next       = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = va_ext[DATA_WIDTH-1:0];
        mem_re         = 1'b0;
        mem_raddr      = cnt_m1[AW-1:0];
        st_clear       = 1'b0;
        div_start      = 1'b0;
        busy           = (state_reg != ST_IDLE);
        done           = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    status_next    = STATUS_OK;
                    stats_req_next = 1'b0;
                    vb_next        = vb_ext[DATA_WIDTH-1:0];
                    idx_next       = '0;
                    unique case (cmd.func)
                        FUNC_PUSH:
                        begin
                            if (cnt_full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FUNC_PUSH_PAIR:
                        begin
                            if (!room2)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (cnt_zero)
                            begin
                                status_next = STATUS_UNDER;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                            end
                        end
                        FUNC_POP_PAIR:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                status_next = STATUS_UNDER;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(2);
                            end
                        end
                        FUNC_POP_COUNT:
                        begin
                            if (!pop_ok)
                            begin
                                status_next = STATUS_UNDER;
                            end
                            else
                            begin
                                count_next = count_reg - amount_x[CW-1:0];
                            end
                        end
                        FUNC_READ_TOP:
                        begin
                            if (cnt_zero)
                            begin
                                status_next = STATUS_UNDER;
                            end
                        end
                        FUNC_STATS:
                        begin
                            if (cnt_zero)
                            begin
                                status_next = STATUS_UNDER;
                            end
                            else
                            begin
                                st_clear       = 1'b1;
                                stats_req_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PUSH2:
            begin
                // second value of the pair lands on top
                mem_we     = 1'b1;
                mem_wdata  = vb_reg;
                count_next = count_reg + 1'b1;
            end
            ST_SCAN:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_reg[AW-1:0];
                idx_next  = idx_reg + 1'b1;
            end
            ST_DSTART: div_start = 1'b1;
            // writes finish in the state before READ, so the top read sees them
            ST_READ:   mem_re = !cnt_zero;
            default: ;
        endcase
    end

    assign scan_vld_next = (state_reg == ST_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            status_reg    <= STATUS_OK;
            stats_req_reg <= 1'b0;
            scan_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            stats_req_reg <= stats_req_next;
            scan_vld_reg  <= scan_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vb_reg  <= vb_next;
        idx_reg <= idx_next;
    end

    assign top_ext = SUM_W'($signed(mem_rdata));
    assign min_ext = SUM_W'(st_min);
    assign max_ext = SUM_W'(st_max);
    assign odd_cnt = count_reg - st_even;
    assign even_x  = XW'(st_even);
    assign odd_x   = XW'(odd_cnt);

    always_comb
    begin
        result             = '0;
        result.status      = status_reg;
        result.top_value   = cnt_zero ? '0 : top_ext[VAL_W-1:0];
        result.entry_count = count_x[CNT_W-1:0];
        result.is_empty    = cnt_zero;
        result.is_full     = cnt_full;
        if (stats_req_reg)
        begin
            result.mean_value = div_quot[VAL_W-1:0];
            result.min_value  = min_ext[VAL_W-1:0];
            result.max_value  = max_ext[VAL_W-1:0];
            result.even_count = even_x[CNT_W-1:0];
            result.odd_count  = odd_x[CNT_W-1:0];
        end
    end

    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= DEPTH_C, "entry count beyond depth")
    `ASSERT_IMPL(a_write_room, mem_we, !cnt_full, "write into a full stack")
    `ASSERT_IMPL(a_div_state, div_done, state_reg == ST_DIV, "divider done outside wait")
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule
